FILE: design/dbpc_pkg.sv
// ----------------------------------------------------------------------------
// Dual button press classifier package
// Shared types, class and kind codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbpc_pkg;

  // Default width of the internal time base.
  localparam int unsigned TIME_BITS_DEF = 32;

  // Width of the timestamp and duration fields on the ports.
  localparam int unsigned PORT_TIME_W = 32;

  // Width of one threshold register.
  localparam int unsigned THR_W = 16;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK       = 2'd2;

  // Threshold reset values in ms.
  localparam logic [THR_W-1:0] SHORT_PRESS_RST = 16'd50;
  localparam logic [THR_W-1:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [THR_W-1:0] STUCK_RST       = 16'd10000;

  // Button class kept between polls.
  typedef enum logic [2:0] {
    CLS_RELEASED = 3'd0,
    CLS_PRESSED  = 3'd1,
    CLS_SHORT    = 3'd2,
    CLS_LONG     = 3'd3,
    CLS_STUCK    = 3'd4
  } cls_e;

  // Reported event kind.
  typedef enum logic [1:0] {
    KIND_SHORT = 2'd0,
    KIND_LONG  = 2'd1,
    KIND_STUCK = 2'd2
  } kind_e;

  // Threshold set handed to each button.
  typedef struct packed {
    logic [THR_W-1:0] short_ms;
    logic [THR_W-1:0] long_ms;
    logic [THR_W-1:0] stuck_ms;
  } thr_t;

  // Per-button result of one poll.
  typedef struct packed {
    logic                   report;
    kind_e                  kind;
    logic [PORT_TIME_W-1:0] duration;
    logic                   released;
  } btn_res_t;

endpackage

`default_nettype wire

FILE: design/dbpc_btn.sv
// ----------------------------------------------------------------------------
// Dual button press classifier: one button
// Holds the class and press start of one button and classifies each poll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbpc_btn #(
  parameter int unsigned TIME_BITS = dbpc_pkg::TIME_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic                 level_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire dbpc_pkg::thr_t       thr_i,
  output dbpc_pkg::btn_res_t        res_o
);

  dbpc_pkg::cls_e       cls_q, cls_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] held;
  logic [TIME_BITS-1:0] dur_full;
  logic                 was_held;
  logic                 rep;
  dbpc_pkg::kind_e      kind;

  // Hold time against the old start, and whether the button was held.
  assign held     = now_i - start_q;
  assign was_held = cls_q inside {dbpc_pkg::CLS_PRESSED, dbpc_pkg::CLS_LONG,
                                  dbpc_pkg::CLS_STUCK};

  // Next class. Stuck is tested before long.
  always_comb begin
    cls_d = dbpc_pkg::CLS_RELEASED;
    if (level_i) begin
      if (was_held && held >= TIME_BITS'(thr_i.stuck_ms)) begin
        cls_d = dbpc_pkg::CLS_STUCK;
      end else if (was_held && held >= TIME_BITS'(thr_i.long_ms)) begin
        cls_d = dbpc_pkg::CLS_LONG;
      end else begin
        cls_d = dbpc_pkg::CLS_PRESSED;
      end
    end else if (was_held && held >= TIME_BITS'(thr_i.short_ms)
                 && held < TIME_BITS'(thr_i.long_ms)) begin
      cls_d = dbpc_pkg::CLS_SHORT;
    end
  end

  // A new hold begins when the button is seen down after a non-held class.
  assign start_d  = (level_i && !was_held) ? now_i : start_q;
  assign dur_full = now_i - start_d;

  // Long repeats every poll; short and stuck are reported on entry only.
  assign rep = (cls_d == dbpc_pkg::CLS_SHORT || cls_d == dbpc_pkg::CLS_LONG
                || cls_d == dbpc_pkg::CLS_STUCK)
               && (cls_d != cls_q || cls_d == dbpc_pkg::CLS_LONG);

  always_comb begin
    case (cls_d)
      dbpc_pkg::CLS_LONG:  kind = dbpc_pkg::KIND_LONG;
      dbpc_pkg::CLS_STUCK: kind = dbpc_pkg::KIND_STUCK;
      default:             kind = dbpc_pkg::KIND_SHORT;
    endcase
  end

  assign res_o.report   = rep;
  assign res_o.kind     = rep ? kind : dbpc_pkg::KIND_SHORT;
  assign res_o.duration = rep ? dbpc_pkg::PORT_TIME_W'(dur_full) : '0;
  assign res_o.released = (cls_d == dbpc_pkg::CLS_RELEASED);

  // Button state advances once per poll that moves to the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q   <= dbpc_pkg::CLS_RELEASED;
      start_q <= '0;
    end else if (adv_i) begin
      cls_q   <= cls_d;
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/dual_button_press_classifier_core.sv
// Throughput: one poll word per cycle; the input and result registers form a
// two-stage pipeline that advances whenever the result register is free.
// Reset: asynchronous, active low; clears both button classes to released,
// both press starts to zero, the thresholds to 50, 1000 and 10000 ms and
// empties both stages.
// ----------------------------------------------------------------------------
// Dual button press classifier
// Classifies polls of two buttons into short, long and stuck press events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_button_press_classifier_core #(
  parameter int unsigned TIME_BITS = dbpc_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [dbpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dbpc_pkg::THR_W-1:0]      cfg_data_i,
  // Poll stream.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] plus_level, [1] minus_level, [33:2] now_ms, [39:34] zero
  input  wire logic [39:0]                     s_axis_tdata,
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] report_plus, [1] report_minus, [3:2] plus_kind, [5:4] minus_kind,
  // [37:6] plus_duration_ms, [69:38] minus_duration_ms, [70] idle, [71] zero
  output logic [71:0]                          m_axis_tdata
);

  // Threshold registers.
  dbpc_pkg::thr_t thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.short_ms <= dbpc_pkg::SHORT_PRESS_RST;
      thr_q.long_ms  <= dbpc_pkg::LONG_PRESS_RST;
      thr_q.stuck_ms <= dbpc_pkg::STUCK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dbpc_pkg::REG_SHORT_PRESS: thr_q.short_ms <= cfg_data_i;
        dbpc_pkg::REG_LONG_PRESS:  thr_q.long_ms  <= cfg_data_i;
        dbpc_pkg::REG_STUCK:       thr_q.stuck_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic in_valid_q;
  logic out_valid_q;
  logic out_free;
  logic adv;
  logic in_fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register.
  logic                             plus_q;
  logic                             minus_q;
  logic [dbpc_pkg::PORT_TIME_W-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      plus_q  <= s_axis_tdata[0];
      minus_q <= s_axis_tdata[1];
      now_q   <= s_axis_tdata[33:2];
    end
  end

  // Per-button classification.
  logic [TIME_BITS-1:0] now_t;
  dbpc_pkg::btn_res_t   plus_res;
  dbpc_pkg::btn_res_t   minus_res;

  assign now_t = TIME_BITS'(now_q);

  dbpc_btn #(
    .TIME_BITS(TIME_BITS)
  ) u_plus (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .level_i(plus_q),
    .now_i  (now_t),
    .thr_i  (thr_q),
    .res_o  (plus_res)
  );

  dbpc_btn #(
    .TIME_BITS(TIME_BITS)
  ) u_minus (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .level_i(minus_q),
    .now_i  (now_t),
    .thr_i  (thr_q),
    .res_o  (minus_res)
  );

  // Result register.
  logic [71:0] out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {1'b0,
                plus_res.released && minus_res.released,
                minus_res.duration,
                plus_res.duration,
                minus_res.kind,
                plus_res.kind,
                minus_res.report,
                plus_res.report};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

FILE: design/dbpc_checker.sv
// ----------------------------------------------------------------------------
// Dual button press classifier checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbpc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata
);

  // A stalled result word keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  // A stalled result word keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // Without a report, kind and duration of that button read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[0] || (m_axis_tdata[3:2] == 2'd0 && m_axis_tdata[37:6] == 32'd0))
      && (m_axis_tdata[1] || (m_axis_tdata[5:4] == 2'd0 && m_axis_tdata[69:38] == 32'd0)))
    else $error("unreported button carries kind or duration");

  // Kind code three is never produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:2] != 2'd3 && m_axis_tdata[5:4] != 2'd3)
    else $error("undefined event kind");

  // Idle means both released, so no long or stuck report comes with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[70] |->
      !(m_axis_tdata[0] && m_axis_tdata[3:2] != 2'd0)
      && !(m_axis_tdata[1] && m_axis_tdata[5:4] != 2'd0))
    else $error("idle reported with a held button event");

endmodule

bind dual_button_press_classifier_core dbpc_checker u_dbpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

FILE: tb/tb_dual_button_press_classifier_core.sv
// ----------------------------------------------------------------------------
// Dual button press classifier testbench
// Streams polls of the plus and minus buttons into the core across several
// threshold settings, predicts every result word from its own copy of the
// button classes and press start times, and compares each result field by
// field. Both stream sides idle at random, and the result side holds off
// once for a long stretch so that the pipeline fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dual_button_press_classifier_core;
  import dbpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          LONG_HOLD   = 300;
  localparam int          RAND_POLLS  = 220;
  localparam int          NUM_PHASES  = 7;

  // Expected event of one button in one poll.
  typedef struct {
    logic        report;
    kind_e       kind;
    logic [31:0] duration;
  } btn_event_t;

  // Expected result word of one poll.
  typedef struct {
    btn_event_t plus;
    btn_event_t minus;
    logic       idle;
  } poll_result_t;

  // Predicts result words from accepted polls and checks the words that arrive.
  class press_scoreboard;
    logic [THR_W-1:0] short_thr;
    logic [THR_W-1:0] long_thr;
    logic [THR_W-1:0] stuck_thr;
    cls_e             plus_cls;
    cls_e             minus_cls;
    logic [31:0]      plus_start;
    logic [31:0]      minus_start;
    poll_result_t     pending_results[$];
    int               errors;
    int               printed;

    function new();
      short_thr   = SHORT_PRESS_RST;
      long_thr    = LONG_PRESS_RST;
      stuck_thr   = STUCK_RST;
      plus_cls    = CLS_RELEASED;
      minus_cls   = CLS_RELEASED;
      plus_start  = '0;
      minus_start = '0;
      errors      = 0;
      printed     = 0;
    endfunction

    function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
      case (idx)
        REG_SHORT_PRESS: short_thr = val;
        REG_LONG_PRESS:  long_thr  = val;
        REG_STUCK:       stuck_thr = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Pressed, long and stuck keep a press going; short does not.
    function bit is_holding(cls_e c);
      return (c == CLS_PRESSED) || (c == CLS_LONG) || (c == CLS_STUCK);
    endfunction

    // Advances one button by one poll and returns its event.
    function void classify_button(input logic level, input logic [31:0] now,
                                  inout cls_e cls, inout logic [31:0] start,
                                  output btn_event_t ev);
      logic [31:0] hold;
      logic        was;
      cls_e        nxt;
      hold = now - start;
      was  = is_holding(cls);
      // Stuck is tested before long, and both only while a press goes on.
      if (level) begin
        if (was && hold >= stuck_thr) nxt = CLS_STUCK;
        else if (was && hold >= long_thr) nxt = CLS_LONG;
        else nxt = CLS_PRESSED;
      end else if (was && hold >= short_thr && hold < long_thr) begin
        nxt = CLS_SHORT;
      end else begin
        nxt = CLS_RELEASED;
      end
      // A new press takes its start time after the class has been decided.
      if (!was && level) start = now;
      ev.report = (nxt != CLS_RELEASED) && (nxt != CLS_PRESSED) &&
                  ((nxt != cls) || (nxt == CLS_LONG));
      if (ev.report && nxt == CLS_LONG) ev.kind = KIND_LONG;
      else if (ev.report && nxt == CLS_STUCK) ev.kind = KIND_STUCK;
      else ev.kind = KIND_SHORT;
      ev.duration = ev.report ? now - start : 32'd0;
      cls = nxt;
    endfunction

    function void note_poll(logic p, logic m, logic [31:0] now);
      poll_result_t r;
      classify_button(p, now, plus_cls, plus_start, r.plus);
      classify_button(m, now, minus_cls, minus_start, r.minus);
      r.idle = (plus_cls == CLS_RELEASED) && (minus_cls == CLS_RELEASED);
      pending_results.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        if (printed < 80) begin
          printed++;
          $display("%0t ns: %s expected %h, got %h", $time, name, exp_v, act_v);
        end
      end
    endfunction

    function void check_word(logic [71:0] w);
      poll_result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (printed < 80) begin
          printed++;
          $display("%0t ns: result word %h expected none, got one", $time, w);
        end
        return;
      end
      e = pending_results.pop_front();
      compare("report_plus", 32'(e.plus.report), 32'(w[0]));
      compare("report_minus", 32'(e.minus.report), 32'(w[1]));
      compare("plus_kind", 32'(e.plus.kind), 32'(w[3:2]));
      compare("minus_kind", 32'(e.minus.kind), 32'(w[5:4]));
      compare("plus_duration_ms", e.plus.duration, w[37:6]);
      compare("minus_duration_ms", e.minus.duration, w[69:38]);
      compare("idle", 32'(e.idle), 32'(w[70]));
      compare("pad bit", 32'd0, 32'(w[71]));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [THR_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [0] plus_level, [1] minus_level, [33:2] now_ms, [39:34] zero
  logic [39:0]          s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [0] report_plus, [1] report_minus, [3:2] plus_kind, [5:4] minus_kind,
  // [37:6] plus_duration_ms, [69:38] minus_duration_ms, [70] idle, [71] zero
  logic [71:0]          m_axis_tdata;

  press_scoreboard sb;
  bit              tx_quiet      = 1'b0;
  bit              rx_quiet      = 1'b0;
  bit              hold_off_req  = 1'b0;
  int unsigned     cycles        = 0;
  logic [31:0]     poll_time;
  logic            plus_lvl;
  logic            minus_lvl;

  dual_button_press_classifier_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one poll word after a random gap and waits until it is taken.
  task automatic send_poll(input logic p, input logic m, input logic [31:0] now);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, now, m, p};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_poll(p, m, now);
  endtask

  // Stops offering words and waits for every result still expected.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [THR_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_threshold(idx, val);
  endtask

  // Mostly presses held across the thresholds, with some timestamp noise.
  task automatic random_polls(input int n, input bit with_hold_off);
    int unsigned step;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_quiet = ($urandom_range(0, 2) == 0);
        rx_quiet = ($urandom_range(0, 2) == 0);
      end
      if (with_hold_off && i == 60) hold_off_req = 1'b1;
      if ($urandom_range(0, 99) < 12) begin
        poll_time = $urandom;
        plus_lvl  = 1'($urandom_range(0, 1));
        minus_lvl = 1'($urandom_range(0, 1));
      end else begin
        case ($urandom_range(0, 4))
          0: step = $urandom_range(0, 3);
          1: step = $urandom_range(0, sb.short_thr);
          2: step = $urandom_range(sb.short_thr, sb.long_thr);
          3: step = $urandom_range(sb.long_thr, sb.stuck_thr);
          default: step = $urandom_range(0, sb.stuck_thr + 16);
        endcase
        poll_time = poll_time + step;
        if ($urandom_range(0, 2) == 0) plus_lvl = ~plus_lvl;
        if ($urandom_range(0, 2) == 0) minus_lvl = ~minus_lvl;
      end
      send_poll(plus_lvl, minus_lvl, poll_time);
    end
  endtask

  // Result side: random stalls per word, one long hold-off on request.
  initial begin : result_sink
    int wait_cyc;
    wait_cyc      = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        wait_cyc = LONG_HOLD;
      end
      m_axis_tready <= (wait_cyc == 0);
      if (wait_cyc > 0) wait_cyc--;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tdata);
        wait_cyc = rx_quiet ? 0 : $urandom_range(0, 7);
      end
    end
  end

  // Poll source and run control.
  initial begin : poll_source
    logic [THR_W-1:0] s_v;
    logic [THR_W-1:0] l_v;
    logic [THR_W-1:0] k_v;
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SHORT_PRESS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    poll_time     = '0;
    plus_lvl      = 1'b0;
    minus_lvl     = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed polls under the reset thresholds.
    send_poll(1'b0, 1'b0, 32'd0);
    send_poll(1'b1, 1'b1, 32'd1000);
    send_poll(1'b1, 1'b1, 32'd1040);
    // Release inside the short window.
    send_poll(1'b0, 1'b1, 32'd1060);
    // A press right after a short press starts a new hold.
    send_poll(1'b1, 1'b1, 32'd1070);
    // Minus turns long and repeats.
    send_poll(1'b1, 1'b1, 32'd2000);
    send_poll(1'b1, 1'b1, 32'd2001);
    send_poll(1'b0, 1'b1, 32'd2010);
    // Minus turns stuck, reported once.
    send_poll(1'b1, 1'b1, 32'd11000);
    send_poll(1'b1, 1'b1, 32'd11001);
    // Releases too early and after a long hold both go to released.
    send_poll(1'b0, 1'b0, 32'd11005);
    send_poll(1'b1, 1'b0, 32'd20000);
    send_poll(1'b1, 1'b0, 32'd21500);
    send_poll(1'b0, 1'b0, 32'd21600);
    // Hold across the timestamp wrap.
    send_poll(1'b1, 1'b0, 32'hFFFF_FFF0);
    send_poll(1'b1, 1'b0, 32'h0000_0030);
    send_poll(1'b0, 1'b0, 32'h0000_0050);
    // Timestamp extremes and alternating bit patterns.
    send_poll(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_poll(1'b0, 1'b0, 32'h0000_0000);
    send_poll(1'b1, 1'b1, 32'hAAAA_AAAA);
    send_poll(1'b0, 1'b0, 32'h5555_5555);
    drain_results();

    // Threshold settings: smallest, largest, reversed, typical, random ones,
    // and back to the reset values.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin s_v = 16'd10;    l_v = 16'd11;    k_v = 16'd12;    end
        1: begin s_v = 16'd65535; l_v = 16'd65535; k_v = 16'd65535; end
        2: begin s_v = 16'd400;   l_v = 16'd150;   k_v = 16'd60;    end
        3: begin s_v = 16'd20;    l_v = 16'd200;   k_v = 16'd800;   end
        4: begin
          s_v = THR_W'($urandom_range(10, 300));
          l_v = THR_W'(s_v + $urandom_range(1, 2000));
          k_v = THR_W'(l_v + $urandom_range(1, 5000));
        end
        5: begin
          s_v = THR_W'($urandom_range(10, 65535));
          l_v = THR_W'($urandom_range(11, 65535));
          k_v = THR_W'($urandom_range(12, 65535));
        end
        default: begin s_v = SHORT_PRESS_RST; l_v = LONG_PRESS_RST; k_v = STUCK_RST; end
      endcase
      write_threshold(REG_SHORT_PRESS, s_v);
      write_threshold(REG_LONG_PRESS, l_v);
      write_threshold(REG_STUCK, k_v);
      random_polls(RAND_POLLS, ph == 3);
      drain_results();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
